// ===== sv/kfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared constants for the KISS frame decoder: framing codes, command
// nibbles, result kinds and the default frame length limit.
// ----------------------------------------------------------------------------
package kfd_pkg;

	// framing codes of the KISS stream
	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;

	// command nibble of the type byte
	localparam logic [3:0] CMD_FRAME_DATA  = 4'd0;
	localparam logic [3:0] CMD_TX_DELAY    = 4'd1;
	localparam logic [3:0] CMD_PERSISTENCE = 4'd2;
	localparam logic [3:0] CMD_SLOT_TIME   = 4'd3;
	localparam logic [3:0] CMD_TX_TAIL     = 4'd4;
	localparam logic [3:0] CMD_FULL_DUPLEX = 4'd5;
	localparam logic [3:0] CMD_HARDWARE    = 4'd6;
	localparam logic [3:0] CMD_RETURN      = 4'd15;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_EOF     = 1'b1;

	// default limit on decoded bytes kept per frame
	localparam int FRAME_BYTES_DEF = 1024;

endpackage : kfd_pkg
`default_nettype wire

// ===== sv/kiss_frame_decoder.sv =====
// An accepted byte is held in the input register, decoded, and its result registered in the result register.
// Throughput: one byte per cycle; the input register and the result register each
// take a new request whenever the result register is empty or being drained.
// A byte that gives no result still takes its slot in the single decode stage.
// Reset (arst_n low, asynchronous): idle outside a frame, settings zero, KISS mode on.
`default_nettype none
// ----------------------------------------------------------------------------
// kiss_frame_decoder
// KISS deframer: undoes FEND/FESC escaping, splits the type byte into port
// and command, emits data-frame payload bytes and an end-of-frame report,
// and applies setting and return commands when a frame closes.
// ----------------------------------------------------------------------------
module kiss_frame_decoder
	import kfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic [3:0]      port,
	output logic [3:0]      command,
	output logic [7:0]      tx_delay_now,
	output logic [7:0]      persistence_now,
	output logic [7:0]      slot_time_now,
	output logic [7:0]      tx_tail_now,
	output logic            duplex_now,
	output logic [7:0]      hardware_now,
	output logic            mode_now
);

	localparam int CNT_W = $clog2(FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_BYTES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state
	logic             frame_q, esc_q, mode_q, duplex_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       type_q, arg_q;
	logic [7:0]       txd_q, pers_q, slot_q, tail_q, hw_q;

	// next state
	logic             frame_n, esc_n, mode_n, duplex_n;
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       type_n, arg_n;
	logic [7:0]       txd_n, pers_n, slot_n, tail_n, hw_n;
	logic             res_v, res_kind;
	logic [7:0]       res_data, dec;
	logic             adv, step;

	// result register
	logic       out_valid_q;
	logic       kind_q, duplex_out_q, mode_out_q;
	logic [7:0] data_q, type_out_q, txd_out_q, pers_out_q, slot_out_q, tail_out_q, hw_out_q;

	// stage advances whenever the result register is free or being taken
	assign adv      = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// decode one byte against the frame state
	always_comb begin
		frame_n  = frame_q;
		esc_n    = esc_q;
		cnt_n    = cnt_q;
		type_n   = type_q;
		arg_n    = arg_q;
		txd_n    = txd_q;
		pers_n   = pers_q;
		slot_n   = slot_q;
		tail_n   = tail_q;
		duplex_n = duplex_q;
		hw_n     = hw_q;
		mode_n   = mode_q;
		res_v    = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_data = 8'd0;
		dec      = byte_s1;
		if (esc_q) begin
			if (byte_s1 == TFESC) begin
				dec = FESC;
			end else if (byte_s1 == TFEND) begin
				dec = FEND;
			end
		end
		if (step) begin
			if (!frame_q) begin
				// hunting for an opening frame end
				if (byte_s1 == FEND) begin
					frame_n = 1'b1;
					esc_n   = 1'b0;
					cnt_n   = '0;
				end
			end else if (byte_s1 == FEND) begin
				// closing frame end: apply command, report non-empty frames
				frame_n = 1'b0;
				esc_n   = 1'b0;
				if (cnt_q != '0) begin
					res_v    = 1'b1;
					res_kind = KIND_EOF;
					case (type_q[3:0])
						CMD_TX_DELAY:    if (cnt_q >= CNT_TWO) txd_n = arg_q;
						CMD_PERSISTENCE: if (cnt_q >= CNT_TWO) pers_n = arg_q;
						CMD_SLOT_TIME:   if (cnt_q >= CNT_TWO) slot_n = arg_q;
						CMD_TX_TAIL:     if (cnt_q >= CNT_TWO) tail_n = arg_q;
						CMD_FULL_DUPLEX: if (cnt_q >= CNT_TWO) duplex_n = (arg_q != 8'd0);
						CMD_HARDWARE:    if (cnt_q >= CNT_TWO) hw_n = arg_q;
						CMD_RETURN:      mode_n = 1'b0;
						default:         ;
					endcase
				end
			end else if (byte_s1 == FESC) begin
				esc_n = 1'b1;
			end else begin
				// decoded byte, dropped once the frame is full
				esc_n = 1'b0;
				if (cnt_q != CNT_MAX) begin
					if (cnt_q == '0) begin
						type_n = dec;
						cnt_n  = CNT_ONE;
					end else begin
						if (cnt_q == CNT_ONE) begin
							arg_n = dec;
						end
						cnt_n = cnt_q + CNT_ONE;
						if (type_q[3:0] == CMD_FRAME_DATA) begin
							res_v    = 1'b1;
							res_kind = KIND_PAYLOAD;
							res_data = dec;
						end
					end
				end
			end
		end
	end

	// frame state and settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= 1'b0;
			esc_q    <= 1'b0;
			cnt_q    <= '0;
			type_q   <= 8'd0;
			arg_q    <= 8'd0;
			txd_q    <= 8'd0;
			pers_q   <= 8'd0;
			slot_q   <= 8'd0;
			tail_q   <= 8'd0;
			duplex_q <= 1'b0;
			hw_q     <= 8'd0;
			mode_q   <= 1'b1;
		end else begin
			frame_q  <= frame_n;
			esc_q    <= esc_n;
			cnt_q    <= cnt_n;
			type_q   <= type_n;
			arg_q    <= arg_n;
			txd_q    <= txd_n;
			pers_q   <= pers_n;
			slot_q   <= slot_n;
			tail_q   <= tail_n;
			duplex_q <= duplex_n;
			hw_q     <= hw_n;
			mode_q   <= mode_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			kind_q       <= res_kind;
			data_q       <= res_data;
			type_out_q   <= type_n;
			txd_out_q    <= txd_n;
			pers_out_q   <= pers_n;
			slot_out_q   <= slot_n;
			tail_out_q   <= tail_n;
			duplex_out_q <= duplex_n;
			hw_out_q     <= hw_n;
			mode_out_q   <= mode_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign data_byte       = data_q;
	assign port            = type_out_q[7:4];
	assign command         = type_out_q[3:0];
	assign tx_delay_now    = txd_out_q;
	assign persistence_now = pers_out_q;
	assign slot_time_now   = slot_out_q;
	assign tx_tail_now     = tail_out_q;
	assign duplex_now      = duplex_out_q;
	assign hardware_now    = hw_out_q;
	assign mode_now        = mode_out_q;

	// checks
	a_mode_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!mode_q |=> !mode_q)
		else $error("mode flag set again after return command");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("byte count beyond frame limit");

	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> frame_q)
		else $error("escape pending outside a frame");

	a_payload_data_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_PAYLOAD) |-> (type_out_q[3:0] == CMD_FRAME_DATA))
		else $error("payload result from a non-data frame");

	a_request_taken: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request lost in input stage");

endmodule : kiss_frame_decoder
`default_nettype wire

// ===== tb/kfd_checker.sv =====
// ----------------------------------------------------------------------------
// kfd_checker
// Watches both channels of the KISS frame decoder. Every accepted raw byte
// is run through a local deframer model that mirrors escaping, frame
// length limiting and setting commands. The expected payload bytes and
// end-of-frame reports are queued and compared field by field against
// each accepted result.
// ----------------------------------------------------------------------------
module kfd_checker
	import kfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	input  logic [3:0] port,
	input  logic [3:0] command,
	input  logic [7:0] tx_delay_now,
	input  logic [7:0] persistence_now,
	input  logic [7:0] slot_time_now,
	input  logic [7:0] tx_tail_now,
	input  logic       duplex_now,
	input  logic [7:0] hardware_now,
	input  logic       mode_now,
	output int         errors,
	output int         pending,
	output int         payload_seen,
	output int         reports_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic [3:0] port;
		logic [3:0] cmd;
		logic [7:0] tx_delay;
		logic [7:0] persist;
		logic [7:0] slot;
		logic [7:0] tail;
		logic       duplex;
		logic [7:0] hw;
		logic       mode;
	} kiss_result_t;

	// deframer state as the decoder should hold it
	logic        framing;
	logic        esc_held;
	int unsigned kept;
	logic [7:0]  type_p;
	logic [7:0]  arg_p;
	logic [7:0]  txd_p;
	logic [7:0]  pers_p;
	logic [7:0]  slot_p;
	logic [7:0]  tail_p;
	logic        dup_p;
	logic [7:0]  hw_p;
	logic        mode_p;

	kiss_result_t kiss_results_q[$];

	// one line per mismatch
	task automatic report(input string what);
		errors++;
		$display("%0t ns  mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want_v);
		if (got !== want_v)
			report($sformatf("%s got %02h expected %02h", name, got, want_v));
	endtask

	// result as it would leave the decoder with the current settings
	function automatic kiss_result_t snapshot(input logic k, input logic [7:0] d);
		kiss_result_t r;
		r.kind     = k;
		r.data     = d;
		r.port     = type_p[7:4];
		r.cmd      = type_p[3:0];
		r.tx_delay = txd_p;
		r.persist  = pers_p;
		r.slot     = slot_p;
		r.tail     = tail_p;
		r.duplex   = dup_p;
		r.hw       = hw_p;
		r.mode     = mode_p;
		return r;
	endfunction

	// decode one raw byte and queue whatever result it causes
	task automatic decode_rx_byte(input logic [7:0] raw);
		logic [7:0] b;
		b = raw;
		// idle: only a frame end opens a frame
		if (!framing) begin
			if (b == FEND) begin
				framing  = 1'b1;
				esc_held = 1'b0;
				kept     = 0;
			end
			return;
		end
		// closing frame end: apply settings, report non-empty frames
		if (b == FEND) begin
			framing  = 1'b0;
			esc_held = 1'b0;
			if (kept == 0)
				return;
			case (type_p[3:0])
				CMD_TX_DELAY:    if (kept >= 2) txd_p = arg_p;
				CMD_PERSISTENCE: if (kept >= 2) pers_p = arg_p;
				CMD_SLOT_TIME:   if (kept >= 2) slot_p = arg_p;
				CMD_TX_TAIL:     if (kept >= 2) tail_p = arg_p;
				CMD_FULL_DUPLEX: if (kept >= 2) dup_p = (arg_p != 8'h00);
				CMD_HARDWARE:    if (kept >= 2) hw_p = arg_p;
				CMD_RETURN:      mode_p = 1'b0;
				default:         ;
			endcase
			kiss_results_q.insert(kiss_results_q.size(), snapshot(KIND_EOF, 8'h00));
			return;
		end
		// escape marker, repeated markers keep the escape pending
		if (b == FESC) begin
			esc_held = 1'b1;
			return;
		end
		if (esc_held) begin
			if (b == TFESC)
				b = FESC;
			else if (b == TFEND)
				b = FEND;
			esc_held = 1'b0;
		end
		// overlong frame: excess bytes dropped
		if (kept >= FRAME_BYTES)
			return;
		if (kept == 0) begin
			type_p = b;
			kept   = 1;
			return;
		end
		if (kept == 1)
			arg_p = b;
		kept++;
		if (type_p[3:0] == CMD_FRAME_DATA)
			kiss_results_q.insert(kiss_results_q.size(), snapshot(KIND_PAYLOAD, b));
	endtask

	// result side first: a byte accepted on this edge cannot have its result yet
	always @(posedge clk or negedge arst_n) begin : watch
		kiss_result_t want;
		if (!arst_n) begin
			framing  = 1'b0;
			esc_held = 1'b0;
			kept     = 0;
			type_p   = 8'h00;
			arg_p    = 8'h00;
			txd_p    = 8'h00;
			pers_p   = 8'h00;
			slot_p   = 8'h00;
			tail_p   = 8'h00;
			dup_p    = 1'b0;
			hw_p     = 8'h00;
			mode_p   = 1'b1;
			kiss_results_q.delete();
			errors       = 0;
			payload_seen = 0;
			reports_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (kiss_results_q.size() == 0) begin
					report("result arrived with nothing expected");
				end else begin
					want = kiss_results_q.pop_front();
					check_field("kind", 8'(kind), 8'(want.kind));
					check_field("data_byte", data_byte, want.data);
					check_field("port", 8'(port), 8'(want.port));
					check_field("command", 8'(command), 8'(want.cmd));
					check_field("tx_delay_now", tx_delay_now, want.tx_delay);
					check_field("persistence_now", persistence_now, want.persist);
					check_field("slot_time_now", slot_time_now, want.slot);
					check_field("tx_tail_now", tx_tail_now, want.tail);
					check_field("duplex_now", 8'(duplex_now), 8'(want.duplex));
					check_field("hardware_now", hardware_now, want.hw);
					check_field("mode_now", 8'(mode_now), 8'(want.mode));
					if (kind)
						reports_seen++;
					else
						payload_seen++;
				end
			end
			if (in_valid && !in_stall)
				decode_rx_byte(rx_byte);
		end
		pending = kiss_results_q.size();
	end

endmodule : kfd_checker

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the KISS frame decoder. A short directed stream
// covers escapes, empty and short frames and every setting command, then
// an overlong data frame runs against a long output hold, then random
// frames, noise and broken sequences run with random gaps on both sides.
// The checker alongside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import kfd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [7:0] data_byte;
	logic [3:0] port;
	logic [3:0] command;
	logic [7:0] tx_delay_now;
	logic [7:0] persistence_now;
	logic [7:0] slot_time_now;
	logic [7:0] tx_tail_now;
	logic       duplex_now;
	logic [7:0] hardware_now;
	logic       mode_now;

	int errors;
	int pending;
	int payload_seen;
	int reports_seen;
	int cycles   = 0;
	int items    = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_req = 1'b0;

	kiss_frame_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.port           (port),
		.command        (command),
		.tx_delay_now   (tx_delay_now),
		.persistence_now(persistence_now),
		.slot_time_now  (slot_time_now),
		.tx_tail_now    (tx_tail_now),
		.duplex_now     (duplex_now),
		.hardware_now   (hardware_now),
		.mode_now       (mode_now)
	);

	kfd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.port           (port),
		.command        (command),
		.tx_delay_now   (tx_delay_now),
		.persistence_now(persistence_now),
		.slot_time_now  (slot_time_now),
		.tx_tail_now    (tx_tail_now),
		.duplex_now     (duplex_now),
		.hardware_now   (hardware_now),
		.mode_now       (mode_now),
		.errors         (errors),
		.pending        (pending),
		.payload_seen   (payload_seen),
		.reports_seen   (reports_seen)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall per request, plus one long hold on demand
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				n = rx_quiet ? 0 : $urandom_range(0, 15);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// one raw byte with a random gap in front, held until accepted
	task automatic send_raw(input logic [7:0] b, input bit counted);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		if (counted)
			items++;
	endtask

	// one decoded byte, escaped as the stream requires, sometimes needlessly
	task automatic send_coded(input logic [7:0] b);
		if (b == FEND) begin
			send_raw(FESC, 1'b1);
			send_raw(TFEND, 1'b1);
		end else if (b == FESC) begin
			send_raw(FESC, 1'b1);
			send_raw(TFESC, 1'b1);
		end else if ($urandom_range(0, 15) == 0 && b != TFEND && b != TFESC) begin
			send_raw(FESC, 1'b1);
			send_raw(b, 1'b1);
		end else begin
			send_raw(b, 1'b1);
		end
	endtask

	// byte values biased towards the framing codes and the extremes
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0:       return FEND;
			1:       return FESC;
			2:       return TFEND;
			3:       return TFESC;
			4:       return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] type_b, input int len);
		int i;
		send_raw(FEND, 1'b1);
		send_coded(type_b);
		for (i = 0; i < len; i++)
			send_coded(pick_byte());
		send_raw(FEND, 1'b1);
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [7:0] directed_q[$];
		logic [7:0] b;
		int         sel;
		int         n;
		int         i;
		int         c;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise, empty frame, then a data frame with every escape form:
		// escaped frame end and escape, repeated escape, escaped plain byte
		directed_q = '{8'hFF, 8'h00, FEND, FEND,
			FEND, 8'hF0, 8'h00, 8'hFF, FESC, TFEND, FESC, TFESC,
			FESC, FESC, 8'h41, FEND};
		foreach (directed_q[i])
			send_raw(directed_q[i], 1'b1);

		// every setting command, first without argument, then at the top of its range
		for (c = CMD_TX_DELAY; c <= CMD_HARDWARE; c++)
			send_frame({4'(c), 4'(c)}, 0);
		for (c = CMD_TX_DELAY; c <= CMD_HARDWARE; c++) begin
			send_raw(FEND, 1'b1);
			send_raw({4'(c), 4'(c)}, 1'b1);
			send_raw(8'hFF, 1'b1);
			send_raw(FEND, 1'b1);
		end

		// unknown command, then frame end right after an escape marker
		directed_q = '{FEND, 8'h79, 8'h55, FEND, FEND, 8'h02, 8'h33, FESC, FEND};
		foreach (directed_q[i])
			send_raw(directed_q[i], 1'b1);

		// overlong data frame against a long output hold
		hold_req = 1'b1;
		tx_quiet = 1'b1;
		send_frame({4'($urandom_range(0, 15)), CMD_FRAME_DATA},
			FRAME_BYTES_DEF + $urandom_range(1, 8));
		tx_quiet = 1'b0;

		// random frames, noise and broken sequences
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			sel = $urandom_range(0, 19);
			if (sel < 10) begin
				send_frame({4'($urandom_range(0, 15)), CMD_FRAME_DATA},
					$urandom_range(0, 10));
			end else if (sel < 14) begin
				send_frame({4'($urandom_range(0, 15)), 4'($urandom_range(1, 6))},
					$urandom_range(0, 2));
			end else if (sel == 14) begin
				send_frame({4'($urandom_range(0, 15)), 4'($urandom_range(7, 14))},
					$urandom_range(0, 3));
			end else if (sel == 15) begin
				send_raw(FEND, 1'b1);
				send_raw(FEND, 1'b1);
			end else if (sel == 16) begin
				// noise outside a frame, ignored by the block
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					do b = pick_byte(); while (b == FEND);
					send_raw(b, 1'b0);
				end
			end else begin
				// broken frame: raw escape codes, maybe a dangling escape at the end
				send_raw(FEND, 1'b1);
				send_coded({4'($urandom_range(0, 15)), 4'($urandom_range(0, 14))});
				n = $urandom_range(0, 6);
				for (i = 0; i < n; i++) begin
					do b = pick_byte(); while (b == FEND);
					send_raw(b, 1'b1);
				end
				if ($urandom_range(0, 1) == 0)
					send_raw(FESC, 1'b1);
				send_raw(FEND, 1'b1);
			end
		end

		// return command, then a data frame seen with the mode flag cleared
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		send_frame({4'($urandom_range(0, 15)), CMD_RETURN}, 0);
		send_frame({4'($urandom_range(0, 15)), CMD_FRAME_DATA}, 3);

		// drain, one edge first so the checker has seen the last request
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("checked %0d payload bytes and %0d frame reports in %0d cycles",
			payload_seen, reports_seen, cycles);
		$display("run held one overlong frame against a %0d-cycle output hold",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule : tb
